### rtl/utf16le_to_utf8_converter_defines.svh
// ---------------------------------------------------------------------------
// utf16le_to_utf8_converter assertion macros
// shared property wrappers, clocked on clk_i and muted while rst_ni is low
// ---------------------------------------------------------------------------
`ifndef UTF16LE_TO_UTF8_CONVERTER_DEFINES_SVH
`define UTF16LE_TO_UTF8_CONVERTER_DEFINES_SVH

// same-cycle implication
`define U16U8_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("u16u8 same-cycle check failed");

// next-cycle implication
`define U16U8_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("u16u8 next-cycle check failed");

`endif

### rtl/u16u8_pkg.sv
// ---------------------------------------------------------------------------
// u16u8_pkg
// shared types, constants and the bmp encoder of the utf-16 to utf-8 block
// ---------------------------------------------------------------------------
package u16u8_pkg;

  // largest byte burst of one transaction: replacement char plus a second one
  localparam int unsigned MaxBytes   = 6;
  localparam int unsigned CntW       = $clog2(MaxBytes + 1);
  localparam int unsigned IdxW       = $clog2(MaxBytes);
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QPtrW      = $clog2(QueueDepth);
  localparam int unsigned QCntW      = $clog2(QueueDepth + 1);

  // surrogate ranges by their top six bits
  localparam logic [5:0]  HighSurPrefix = 6'h36;
  localparam logic [5:0]  LowSurPrefix  = 6'h37;
  localparam logic [15:0] ReplChar      = 16'hFFFD;
  localparam logic [20:0] SuppBase      = 21'h010000;

  typedef struct packed {
    logic [15:0] code_unit;
    logic        last_unit;
  } in_item_t;

  typedef struct packed {
    logic [7:0] utf8_byte;
    logic       end_of_unit;
    logic       end_of_string;
  } out_item_t;

  // one classified transaction, byte 0 goes out first
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [CntW-1:0]          count;
    logic                     last;
  } job_t;

  typedef struct packed {
    logic [2:0][7:0] bytes;
    logic [1:0]      count;
  } seq3_t;

  // 1 to 3 byte encoding of a basic plane code point
  function automatic seq3_t encode_bmp(input logic [15:0] unit);
    seq3_t s;
    s = '0;
    if (unit[15:7] == 9'd0) begin
      s.bytes[0] = {1'b0, unit[6:0]};
      s.count    = 2'd1;
    end else if (unit[15:11] == 5'd0) begin
      s.bytes[0] = {3'b110, unit[10:6]};
      s.bytes[1] = {2'b10, unit[5:0]};
      s.count    = 2'd2;
    end else begin
      s.bytes[0] = {4'b1110, unit[15:12]};
      s.bytes[1] = {2'b10, unit[11:6]};
      s.bytes[2] = {2'b10, unit[5:0]};
      s.count    = 2'd3;
    end
    return s;
  endfunction

endpackage

### rtl/u16u8_front.sv
// ---------------------------------------------------------------------------
// u16u8_front
// accepts code units, tracks the held high surrogate, builds byte jobs
// ---------------------------------------------------------------------------
module u16u8_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  u16u8_pkg::in_item_t in_data_i,
  input  logic                full_i,
  output logic                push_o,
  output u16u8_pkg::job_t     job_o,
  output logic                pending_o
);
  import u16u8_pkg::*;

  logic        pending_q, pending_d;
  logic [9:0]  high_bits_q, high_bits_d;
  logic        accept;
  logic        is_high, is_low, pair;
  logic [20:0] cp;
  seq3_t       sec, repl;
  job_t        job;

  assign is_high = (in_data_i.code_unit[15:10] == HighSurPrefix);
  assign is_low  = (in_data_i.code_unit[15:10] == LowSurPrefix);
  assign pair    = pending_q && is_low;
  assign cp      = SuppBase + {1'b0, high_bits_q, in_data_i.code_unit[9:0]};
  assign repl    = encode_bmp(ReplChar);

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    // unit handled as if nothing were held
    if (is_high && !in_data_i.last_unit) begin
      sec = '0;
    end else if (is_high || is_low) begin
      sec = repl;
    end else begin
      sec = encode_bmp(in_data_i.code_unit);
    end

    job      = '0;
    job.last = in_data_i.last_unit;
    if (pair) begin
      job.bytes[0] = {5'b11110, cp[20:18]};
      job.bytes[1] = {2'b10, cp[17:12]};
      job.bytes[2] = {2'b10, cp[11:6]};
      job.bytes[3] = {2'b10, cp[5:0]};
      job.count    = CntW'(4);
    end else if (pending_q) begin
      job.bytes[2:0] = repl.bytes;
      job.bytes[5:3] = sec.bytes;
      job.count      = CntW'(3) + CntW'(sec.count);
    end else begin
      job.bytes[2:0] = sec.bytes;
      job.count      = CntW'(sec.count);
    end

    pending_d   = pending_q;
    high_bits_d = high_bits_q;
    if (accept) begin
      pending_d   = is_high && !in_data_i.last_unit;
      high_bits_d = pending_d ? in_data_i.code_unit[9:0] : 10'd0;
    end
  end

  assign push_o    = accept && (job.count != '0);
  assign job_o     = job;
  assign pending_o = pending_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= 1'b0;
      high_bits_q <= '0;
    end else begin
      pending_q   <= pending_d;
      high_bits_q <= high_bits_d;
    end
  end

endmodule

### rtl/u16u8_fifo.sv
// ---------------------------------------------------------------------------
// u16u8_fifo
// short job queue between the front and the byte serializer
// ---------------------------------------------------------------------------
module u16u8_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  u16u8_pkg::job_t push_data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output u16u8_pkg::job_t head_o
);
  import u16u8_pkg::*;

  job_t             mem_q [QueueDepth];
  logic [QPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0] count_q, count_d;

  assign full_o  = (count_q == QCntW'(QueueDepth));
  assign empty_o = (count_q == '0);
  assign head_o  = mem_q[rd_ptr_q];

  assign wr_ptr_d = push_i ? wr_ptr_q + QPtrW'(1) : wr_ptr_q;
  assign rd_ptr_d = pop_i ? rd_ptr_q + QPtrW'(1) : rd_ptr_q;
  assign count_d  = count_q + QCntW'(push_i) - QCntW'(pop_i);

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

### rtl/u16u8_back.sv
// ---------------------------------------------------------------------------
// u16u8_back
// walks the head job one byte a cycle into the output register if not stalled
// ---------------------------------------------------------------------------
module u16u8_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 head_valid_i,
  input  u16u8_pkg::job_t      head_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output u16u8_pkg::out_item_t out_data_o
);
  import u16u8_pkg::*;

  logic [IdxW-1:0] idx_q, idx_d;
  logic            out_valid_q, out_valid_d;
  out_item_t       out_q, out_d;
  logic            load, is_last;

  assign load    = head_valid_i && (!out_valid_q || out_ready_i);
  assign is_last = (CntW'(idx_q) == head_i.count - CntW'(1));
  assign pop_o   = load && is_last;

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (load) begin
      out_d.utf8_byte     = head_i.bytes[idx_q];
      out_d.end_of_unit   = is_last;
      out_d.end_of_string = is_last && head_i.last;
      out_valid_d         = 1'b1;
      idx_d               = is_last ? '0 : idx_q + IdxW'(1);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/utf16le_to_utf8_converter.sv
// ---------------------------------------------------------------------------
// utf16le_to_utf8_converter
// utf-16 code units in, utf-8 bytes out, with surrogate pairing and U+FFFD
// ---------------------------------------------------------------------------
//  channel | direction | payload      | handshake
//  --------+-----------+--------------+----------------------
//  in      | input     | in_item_t    | in_valid_i / in_ready_o
//  out     | output    | out_item_t   | out_valid_o / out_ready_i
//
// - one input transaction a cycle while the job queue has room; a transaction
//   yields 0 to 6 output bytes, one byte a cycle while out_ready_i holds
// - sustained input rate is set by the byte serializer: 1 to 3 bytes per
//   basic plane unit, 4 per surrogate pair, up to 6 for broken pairs
// - reset clears the held surrogate, the job queue and the output valid flag
// - a stalled output fills the two-entry queue, then in_ready_o drops
// ---------------------------------------------------------------------------
`include "utf16le_to_utf8_converter_defines.svh"

module utf16le_to_utf8_converter (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  u16u8_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output u16u8_pkg::out_item_t out_data_o
);
  import u16u8_pkg::*;

  // front to queue
  logic push;
  job_t push_job;
  logic full;
  // queue to back
  logic empty;
  logic pop;
  job_t head;
  // held high surrogate, for checks
  logic pending;
  // input transaction terms, for checks
  logic in_fire;
  logic fresh_high;

  // front: classify the unit, pair surrogates, build the byte job
  u16u8_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .full_i     (full),
    .push_o     (push),
    .job_o      (push_job),
    .pending_o  (pending)
  );

  // short job queue decouples classification from byte output
  u16u8_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_job),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .head_o      (head)
  );

  // back: serialize the head job through the output register
  u16u8_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!empty),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

  assign in_fire    = in_valid_i && in_ready_o;
  // high surrogate with nothing held and more units to come
  assign fresh_high = !pending && (in_data_i.code_unit[15:10] == HighSurPrefix) &&
                      !in_data_i.last_unit;

  // a finished job always leaves its closing byte in the output register
  `U16U8_ASSERT_NEXT(a_pop_marks_end, pop, out_valid_o && out_data_o.end_of_unit)
  // the last unit of a string never leaves a surrogate held
  `U16U8_ASSERT_NEXT(a_last_clears_hold, in_fire && in_data_i.last_unit, !pending)
  // a fresh high surrogate that is not last is held and queues nothing
  `U16U8_ASSERT_SAME(a_high_no_push, in_fire && fresh_high, !push)

endmodule

### sim/utf16le_to_utf8_converter_test.sv
// ---------------------------------------------------------------------------
// utf16le_to_utf8_converter_test
// drives utf-16 code units into the converter with random gaps on both
// channels, predicts the utf-8 byte stream, surrogate pairing and U+FFFD
// replacement included, and checks every output byte in order
// ---------------------------------------------------------------------------

// running prediction of the converter plus the bytes still owed by it
class utf8_byte_ledger;
  u16u8_pkg::out_item_t awaited_bytes[$];
  u16u8_pkg::out_item_t burst[$];
  bit                   held_high;
  logic [9:0]           held_bits;
  int                   errors;
  int                   lines_printed;

  function new();
    held_high     = 1'b0;
    held_bits     = '0;
    errors        = 0;
    lines_printed = 0;
  endfunction

  function int outstanding();
    return awaited_bytes.size();
  endfunction

  function void add_byte(logic [7:0] b);
    u16u8_pkg::out_item_t o;
    o.utf8_byte     = b;
    o.end_of_unit   = 1'b0;
    o.end_of_string = 1'b0;
    burst.push_back(o);
  endfunction

  function void put_code_point(logic [20:0] cp);
    if (cp <= 21'h00007F) begin
      add_byte({1'b0, cp[6:0]});
    end else if (cp <= 21'h0007FF) begin
      add_byte({3'b110, cp[10:6]});
      add_byte({2'b10, cp[5:0]});
    end else if (cp <= 21'h00FFFF) begin
      add_byte({4'b1110, cp[15:12]});
      add_byte({2'b10, cp[11:6]});
      add_byte({2'b10, cp[5:0]});
    end else begin
      add_byte({5'b11110, cp[20:18]});
      add_byte({2'b10, cp[17:12]});
      add_byte({2'b10, cp[11:6]});
      add_byte({2'b10, cp[5:0]});
    end
  endfunction

  // one accepted code unit: append the bytes it causes
  function void note_unit(u16u8_pkg::in_item_t item);
    logic [15:0]          u;
    bit                   is_hi;
    bit                   is_lo;
    bit                   paired;
    u16u8_pkg::out_item_t tail;
    u      = item.code_unit;
    is_hi  = (u[15:10] == u16u8_pkg::HighSurPrefix);
    is_lo  = (u[15:10] == u16u8_pkg::LowSurPrefix);
    paired = 1'b0;
    burst.delete();
    if (held_high) begin
      held_high = 1'b0;
      if (is_lo) begin
        put_code_point(u16u8_pkg::SuppBase + {1'b0, held_bits, u[9:0]});
        paired = 1'b1;
      end else begin
        put_code_point({5'd0, u16u8_pkg::ReplChar});
      end
      held_bits = '0;
    end
    if (!paired) begin
      if (is_hi) begin
        if (item.last_unit) begin
          put_code_point({5'd0, u16u8_pkg::ReplChar});
        end else begin
          held_high = 1'b1;
          held_bits = u[9:0];
        end
      end else if (is_lo) begin
        put_code_point({5'd0, u16u8_pkg::ReplChar});
      end else begin
        put_code_point({5'd0, u});
      end
    end
    if (burst.size() > 0) begin
      tail               = burst.pop_back();
      tail.end_of_unit   = 1'b1;
      tail.end_of_string = item.last_unit;
      burst.push_back(tail);
    end
    foreach (burst[k]) awaited_bytes.push_back(burst[k]);
  endfunction

  task report_mismatch(string what, int got, int want);
    errors++;
    if (lines_printed < 40) begin
      lines_printed++;
      $display("mismatch: %s got %0h expected %0h", what, got, want);
    end
  endtask

  task check_byte(u16u8_pkg::out_item_t got);
    u16u8_pkg::out_item_t want;
    if (awaited_bytes.size() == 0) begin
      report_mismatch("unexpected byte", got.utf8_byte, 0);
    end else begin
      want = awaited_bytes.pop_front();
      if (got.utf8_byte != want.utf8_byte)
        report_mismatch("utf8_byte", got.utf8_byte, want.utf8_byte);
      if (got.end_of_unit != want.end_of_unit)
        report_mismatch("end_of_unit", got.end_of_unit, want.end_of_unit);
      if (got.end_of_string != want.end_of_string)
        report_mismatch("end_of_string", got.end_of_string, want.end_of_string);
    end
  endtask
endclass

module utf16le_to_utf8_converter_test;
  import u16u8_pkg::*;

  localparam int RandomUnits  = 234;
  localparam int HoldCycles   = 300;   // long receiver stall that fills the job queue
  localparam int HoldAtBytes  = 150;
  localparam int DrainCycles  = 20;
  localparam int StallLimit   = 3000;  // cycles with no transaction on either side

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_ready_o;
  in_item_t  in_data_i;
  logic      out_valid_o;
  logic      out_ready_i;
  out_item_t out_data_o;

  utf8_byte_ledger ledger;
  int              bytes_seen;
  int              idle_cycles;
  int              random_sent;
  bit              backpressure_done;
  in_item_t        directed_units[26];

  utf16le_to_utf8_converter DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // mostly short gaps, now and then a long one, often none at all
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // present one code unit, hold it until the transaction, then maybe idle
  task automatic offer_unit(input in_item_t item);
    int gap;
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    ledger.note_unit(item);
    @(negedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  // append one character's code units; mostly well formed, some broken
  function automatic void add_character(ref logic [15:0] units[$]);
    int          kind;
    logic [15:0] u;
    logic [19:0] off;
    kind = $urandom_range(0, 99);
    off  = 20'($urandom);
    if (kind < 25) begin
      units.push_back(16'($urandom_range(16'h0000, 16'h007F)));
    end else if (kind < 45) begin
      units.push_back(16'($urandom_range(16'h0080, 16'h07FF)));
    end else if (kind < 60) begin
      // three-byte range with the surrogate block skipped
      u = 16'($urandom_range(16'h0800, 16'hF7FF));
      if (u[15:11] >= 5'b11011) u = u + 16'h0800;
      units.push_back(u);
    end else if (kind < 88) begin
      units.push_back({HighSurPrefix, off[19:10]});
      units.push_back({LowSurPrefix, off[9:0]});
    end else if (kind < 92) begin
      // lone high surrogate, broken by whatever follows or by the string end
      units.push_back({HighSurPrefix, off[9:0]});
    end else if (kind < 96) begin
      units.push_back({LowSurPrefix, off[9:0]});
    end else begin
      units.push_back(16'($urandom_range(0, 16'hFFFF)));
    end
  endfunction

  task automatic offer_string();
    logic [15:0] units[$];
    in_item_t    item;
    repeat ($urandom_range(1, 6)) add_character(units);
    foreach (units[k]) begin
      item.code_unit = units[k];
      item.last_unit = (k == units.size() - 1);
      offer_unit(item);
    end
    random_sent += units.size();
  endtask

  // output side: each byte transaction is checked against the prediction
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      ledger.check_byte(out_data_o);
      bytes_seen++;
    end
  end

  // watchdog: a hung block stops both channels
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= StallLimit) begin
        $display("utf16le_to_utf8_converter_test: errors");
        $finish;
      end
    end
  end

  // receiver: random ready pattern plus one long stall to fill the block
  initial begin
    int gap;
    out_ready_i       = 1'b0;
    backpressure_done = 1'b0;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      if (!backpressure_done && bytes_seen >= HoldAtBytes) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        backpressure_done = 1'b1;
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 40)) @(negedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
  end

  // sender: reset, directed corner cases, then random strings and noise
  initial begin
    bit       drained_once;
    in_item_t item;
    ledger       = new();
    random_sent  = 0;
    drained_once = 1'b0;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;

    directed_units = '{
      '{16'h0000, 1'b0}, '{16'h007F, 1'b0},   // one-byte edges, zero unit
      '{16'h0080, 1'b0}, '{16'h07FF, 1'b0},   // two-byte edges
      '{16'h0800, 1'b0}, '{16'hFFFF, 1'b0},   // three-byte edges
      '{16'hD7FF, 1'b0}, '{16'hE000, 1'b1},   // just outside the surrogates
      '{16'hD800, 1'b0}, '{16'hDC00, 1'b0},   // lowest supplementary point
      '{16'hDBFF, 1'b0}, '{16'hDFFF, 1'b1},   // highest one, ends the string
      '{16'hDC00, 1'b0}, '{16'hDFFF, 1'b0},   // stray low surrogates
      '{16'hD801, 1'b0}, '{16'h0041, 1'b0},   // held high broken by ascii
      '{16'hD83D, 1'b0}, '{16'hD83D, 1'b0},   // held high broken by a high
      '{16'hDE00, 1'b0},                      // which then pairs
      '{16'hD800, 1'b1},                      // lone high as the last unit
      '{16'hDABC, 1'b0}, '{16'hDBFF, 1'b1},   // two replacements in one go
      '{16'hD834, 1'b0}, '{16'h20AC, 1'b1},   // broken by a three-byte unit
      '{16'hFFFD, 1'b0}, '{16'h5555, 1'b1}
    };

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed_units[k]) offer_unit(directed_units[k]);

    while (random_sent < RandomUnits) begin
      // once, halfway: stop sending until the block has delivered everything
      if (!drained_once && random_sent >= RandomUnits / 2) begin
        in_valid_i <= 1'b0;
        while (ledger.outstanding() != 0) @(negedge clk_i);
        drained_once = 1'b1;
      end
      if ($urandom_range(0, 99) < 85) begin
        offer_string();
      end else begin
        item.code_unit = 16'($urandom_range(0, 16'hFFFF));
        item.last_unit = 1'($urandom_range(0, 1));
        offer_unit(item);
        random_sent++;
      end
    end

    in_valid_i <= 1'b0;
    while (ledger.outstanding() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (ledger.errors == 0) begin
      $display("utf16le_to_utf8_converter_test: clean");
    end else begin
      $display("utf16le_to_utf8_converter_test: errors");
    end
    $finish;
  end

endmodule
